FILE: design/assert_macros.svh
// Assertion macros shared by the filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent at one edge forces the consequent at the next edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/drf_pkg.sv
//------------------------------------------------------------------------------
// drf_pkg
// Types and constants shared by the directory-record filter modules.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package drf_pkg;

   localparam int MAX_RESERVED     = 4;
   localparam int MAX_BUFFER_BYTES = 65536;

   localparam int SEEN_W      = $clog2(MAX_BUFFER_BYTES + 1);
   localparam int CSR_IDX_W   = $clog2(MAX_RESERVED + 1);
   localparam int COUNT_W     = 3;
   localparam int FD_W        = 31;
   localparam int OFFS_W      = 16;
   localparam int RLEN_W      = 16;
   localparam int LEN_W       = 17;
   localparam int KIND_W      = 2;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_FIELD_W = 2 * OFFS_W + LEN_W + 1;
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;

   // Queue depth must be a power of two: pointers wrap naturally.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Record layout
   localparam logic [RLEN_W-1:0] LEN_LO_POS = 16'd16;
   localparam logic [RLEN_W-1:0] LEN_HI_POS = 16'd17;
   localparam logic [RLEN_W-1:0] NAME_POS   = 16'd19;
   localparam logic [RLEN_W-1:0] MIN_RECORD = 16'd20;

   localparam logic [FD_W+3:0] VALUE_LIMIT = 35'h0_7fff_ffff;
   localparam logic [7:0]      CHAR_NUL    = 8'h00;
   localparam logic [7:0]      CHAR_ZERO   = 8'h30;
   localparam logic [7:0]      CHAR_NINE   = 8'h39;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_RESERVED_COUNT   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_RESERVED_FD_BASE = CSR_IDX_W'(1);

   typedef enum logic [KIND_W-1:0] {
      KIND_KEEP   = 2'd0,
      KIND_DROP   = 2'd1,
      KIND_FINISH = 2'd2
   } kind_type;

   typedef logic [MAX_RESERVED-1:0][FD_W-1:0] fd_table_type;

   // One queue entry: the results caused by one input byte.
   typedef struct packed {
      logic              rec_valid;
      logic              rec_drop;
      logic [OFFS_W-1:0] rec_src;
      logic [OFFS_W-1:0] rec_dst;
      logic [RLEN_W-1:0] rec_len;
      logic              fin_valid;
      logic [LEN_W-1:0]  fin_len;
      logic              fin_mal;
   } entry_type;

endpackage

`default_nettype wire

FILE: design/drf_parse.sv
//------------------------------------------------------------------------------
// drf_parse
// Front end: parse record bytes, classify records, build result entries.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module drf_parse (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  accept,
   input  logic [7:0]                            data_byte,
   input  logic                                  end_of_buffer,
   input  logic [drf_pkg::COUNT_W-1:0]           reserved_count,
   input  drf_pkg::fd_table_type                 reserved_fd,
   output logic                                  push,
   output drf_pkg::entry_type                    entry
);

   logic [drf_pkg::RLEN_W-1:0] pos_ff, pos_in;
   logic [drf_pkg::RLEN_W-1:0] rec_len_ff, rec_len_in;
   logic [drf_pkg::SEEN_W-1:0] rec_start_ff, rec_start_in;
   logic [drf_pkg::SEEN_W-1:0] wr_off_ff, wr_off_in;
   logic [drf_pkg::SEEN_W-1:0] seen_ff, seen_in;
   logic [drf_pkg::FD_W-1:0]   name_val_ff, name_val_in;
   logic                       digits_ok_ff, digits_ok_in;
   logic                       name_empty_ff, name_empty_in;
   logic                       nul_seen_ff, nul_seen_in;
   logic                       dropped_ff, dropped_in;
   logic                       stopped_ff, stopped_in;

   logic [3:0]                 digit;
   logic [drf_pkg::FD_W+3:0]   scaled;
   logic                       is_match;

   assign digit  = 4'(data_byte - drf_pkg::CHAR_ZERO);
   assign scaled = ({4'b0000, name_val_ff} << 3) + ({4'b0000, name_val_ff} << 1)
                 + {{drf_pkg::FD_W{1'b0}}, digit};

   always_comb begin
      pos_in        = pos_ff;
      rec_len_in    = rec_len_ff;
      rec_start_in  = rec_start_ff;
      wr_off_in     = wr_off_ff;
      seen_in       = seen_ff;
      name_val_in   = name_val_ff;
      digits_ok_in  = digits_ok_ff;
      name_empty_in = name_empty_ff;
      nul_seen_in   = nul_seen_ff;
      dropped_in    = dropped_ff;
      stopped_in    = stopped_ff;
      is_match      = 1'b0;
      entry         = '0;

      if (accept) begin
         // count the byte, or stop on an overlong buffer
         if (!stopped_ff && seen_ff >= drf_pkg::SEEN_W'(drf_pkg::MAX_BUFFER_BYTES)) begin
            stopped_in = 1'b1;
         end else if (seen_ff < drf_pkg::SEEN_W'(drf_pkg::MAX_BUFFER_BYTES)) begin
            seen_in = seen_ff + 1'b1;
         end

         if (!stopped_in) begin
            if (pos_ff == drf_pkg::LEN_LO_POS) begin
               rec_len_in = {8'h00, data_byte};
            end else if (pos_ff == drf_pkg::LEN_HI_POS) begin
               rec_len_in = {data_byte, rec_len_ff[7:0]};
               if (rec_len_in < drf_pkg::MIN_RECORD) begin
                  stopped_in = 1'b1;
               end
            end else if (pos_ff >= drf_pkg::NAME_POS && !nul_seen_ff) begin
               if (data_byte == drf_pkg::CHAR_NUL) begin
                  nul_seen_in = 1'b1;
               end else begin
                  name_empty_in = 1'b0;
                  if (data_byte < drf_pkg::CHAR_ZERO || data_byte > drf_pkg::CHAR_NINE) begin
                     digits_ok_in = 1'b0;
                  end else if (digits_ok_ff) begin
                     if (scaled > drf_pkg::VALUE_LIMIT) begin
                        digits_ok_in = 1'b0;
                     end else begin
                        name_val_in = scaled[drf_pkg::FD_W-1:0];
                     end
                  end
               end
            end

            if (!stopped_in) begin
               if (pos_ff >= drf_pkg::NAME_POS &&
                   ({1'b0, pos_ff} + 1'b1) == {1'b0, rec_len_in}) begin
                  if (!nul_seen_in) begin
                     // name never terminated inside the record
                     stopped_in = 1'b1;
                  end else begin
                     for (int i = 0; i < drf_pkg::MAX_RESERVED; i++) begin
                        if (reserved_count > drf_pkg::COUNT_W'(i) &&
                            reserved_fd[i] == name_val_in) begin
                           is_match = 1'b1;
                        end
                     end
                     is_match = is_match && digits_ok_in && !name_empty_in;

                     entry.rec_valid = 1'b1;
                     entry.rec_drop  = is_match;
                     entry.rec_src   = rec_start_ff[drf_pkg::OFFS_W-1:0];
                     entry.rec_dst   = is_match ? '0 : wr_off_ff[drf_pkg::OFFS_W-1:0];
                     entry.rec_len   = rec_len_in;

                     if (is_match) begin
                        dropped_in = 1'b1;
                     end else begin
                        wr_off_in = wr_off_ff + drf_pkg::SEEN_W'(rec_len_in);
                     end
                     rec_start_in  = rec_start_ff + drf_pkg::SEEN_W'(rec_len_in);
                     pos_in        = '0;
                     rec_len_in    = '0;
                     name_val_in   = '0;
                     digits_ok_in  = 1'b1;
                     name_empty_in = 1'b1;
                     nul_seen_in   = 1'b0;
                  end
               end else begin
                  pos_in = pos_ff + 1'b1;
               end
            end
         end

         if (end_of_buffer) begin
            // buffer ended inside a record
            if (!stopped_in && pos_in != '0) begin
               stopped_in = 1'b1;
            end
            entry.fin_valid = 1'b1;
            entry.fin_len   = dropped_in ? drf_pkg::LEN_W'(wr_off_in)
                                         : drf_pkg::LEN_W'(seen_in);
            entry.fin_mal   = stopped_in;

            pos_in        = '0;
            rec_len_in    = '0;
            rec_start_in  = '0;
            wr_off_in     = '0;
            seen_in       = '0;
            name_val_in   = '0;
            digits_ok_in  = 1'b1;
            name_empty_in = 1'b1;
            nul_seen_in   = 1'b0;
            dropped_in    = 1'b0;
            stopped_in    = 1'b0;
         end
      end
   end

   assign push = entry.rec_valid || entry.fin_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         rec_len_ff    <= '0;
         rec_start_ff  <= '0;
         wr_off_ff     <= '0;
         seen_ff       <= '0;
         name_val_ff   <= '0;
         digits_ok_ff  <= 1'b1;
         name_empty_ff <= 1'b1;
         nul_seen_ff   <= 1'b0;
         dropped_ff    <= 1'b0;
         stopped_ff    <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         rec_len_ff    <= rec_len_in;
         rec_start_ff  <= rec_start_in;
         wr_off_ff     <= wr_off_in;
         seen_ff       <= seen_in;
         name_val_ff   <= name_val_in;
         digits_ok_ff  <= digits_ok_in;
         name_empty_ff <= name_empty_in;
         nul_seen_ff   <= nul_seen_in;
         dropped_ff    <= dropped_in;
         stopped_ff    <= stopped_in;
      end
   end

   `ASSERT_ALWAYS(a_offsets_ordered, clock, reset, (wr_off_ff <= rec_start_ff) && (rec_start_ff <= seen_ff), "compacted offset or record start ran past the bytes taken")
   `ASSERT_NEXT(a_finish_clears, clock, reset, push && entry.fin_valid, (seen_ff == '0) && !stopped_ff && (pos_ff == '0), "buffer state not cleared after finish")

endmodule

`default_nettype wire

FILE: design/drf_queue.sv
//------------------------------------------------------------------------------
// drf_queue
// Short queue of result entries between the parser and the output stage.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module drf_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  drf_pkg::entry_type push_entry,
   input  logic               pop,
   output drf_pkg::entry_type head_entry,
   output logic               not_empty,
   output logic               full
);

   drf_pkg::entry_type slot_ff [drf_pkg::QUEUE_DEPTH];

   logic [drf_pkg::QPTR_W-1:0] head_ff, head_in;
   logic [drf_pkg::QPTR_W-1:0] tail_ff, tail_in;
   logic [drf_pkg::QCNT_W-1:0] count_ff, count_in;

   assign not_empty  = (count_ff != '0);
   assign full       = (count_ff == drf_pkg::QCNT_W'(drf_pkg::QUEUE_DEPTH));
   assign head_entry = slot_ff[head_ff];

   always_comb begin
      head_in  = pop  ? head_ff + 1'b1 : head_ff;
      tail_in  = push ? tail_ff + 1'b1 : tail_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // payload slots, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[tail_ff] <= push_entry;
      end
   end

   `ASSERT_ALWAYS(a_no_push_full, clock, reset, !(push && full), "entry written into a full queue")
   `ASSERT_ALWAYS(a_no_pop_empty, clock, reset, !(pop && !not_empty), "entry taken from an empty queue")

endmodule

`default_nettype wire

FILE: design/drf_emit.sv
//------------------------------------------------------------------------------
// drf_emit
// Back end: unpack queue entries into results, one per cycle unless stalled.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module drf_emit (
   input  logic                               clock,
   input  logic                               reset,
   input  drf_pkg::entry_type                 head_entry,
   input  logic                               head_valid,
   output logic                               pop,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [drf_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [drf_pkg::KIND_W-1:0]         rsp_tuser,
   output logic                               rsp_tlast
);

   drf_pkg::entry_type cur_ff, cur_in;
   logic               rec_pend_ff, rec_pend_in;
   logic               fin_pend_ff, fin_pend_in;

   logic               fire;
   logic               rec_left;
   logic               fin_left;
   drf_pkg::kind_type  kind;
   logic [drf_pkg::OFFS_W-1:0] src;
   logic [drf_pkg::OFFS_W-1:0] dst;
   logic [drf_pkg::LEN_W-1:0]  len;
   logic                       mal;

   assign rsp_tvalid = rec_pend_ff || fin_pend_ff;
   assign fire       = rsp_tvalid && rsp_tready;

   // record result goes out ahead of the finish result of the same byte
   assign rec_left = rec_pend_ff && !fire;
   assign fin_left = fin_pend_ff && !(fire && !rec_pend_ff);
   assign pop      = head_valid && !rec_left && !fin_left;

   always_comb begin
      cur_in      = cur_ff;
      rec_pend_in = rec_left;
      fin_pend_in = fin_left;
      if (pop) begin
         cur_in      = head_entry;
         rec_pend_in = head_entry.rec_valid;
         fin_pend_in = head_entry.fin_valid;
      end
   end

   always_comb begin
      if (rec_pend_ff) begin
         kind = cur_ff.rec_drop ? drf_pkg::KIND_DROP : drf_pkg::KIND_KEEP;
         src  = cur_ff.rec_src;
         dst  = cur_ff.rec_dst;
         len  = drf_pkg::LEN_W'(cur_ff.rec_len);
         mal  = 1'b0;
      end else begin
         kind = drf_pkg::KIND_FINISH;
         src  = '0;
         dst  = '0;
         len  = cur_ff.fin_len;
         mal  = cur_ff.fin_mal;
      end
   end

   assign rsp_tuser = kind;
   assign rsp_tlast = !rec_pend_ff;
   assign rsp_tdata = {{(drf_pkg::RSP_DATA_W - drf_pkg::RSP_FIELD_W){1'b0}}, mal, len, dst, src};

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_pend_ff <= 1'b0;
         fin_pend_ff <= 1'b0;
      end else begin
         rec_pend_ff <= rec_pend_in;
         fin_pend_ff <= fin_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

endmodule

`default_nettype wire

FILE: design/dir_record_reserved_fd_filter_top.sv
//------------------------------------------------------------------------------
// dir_record_reserved_fd_filter_top
// Directory-record filter that drops records named after reserved descriptors.
//------------------------------------------------------------------------------
// Usage:
//   req_*  : one buffer byte per transaction, req_tlast on the final byte.
//   rsp_*  : keep/drop verdicts per record, then one finish transaction
//            (rsp_tlast high) carrying the resulting buffer length.
//   csr_*  : register writes, index 0 = reserved_count, 1..4 = reserved_fd;
//            write only while no buffer is in flight. csr_ready is always high.
// Throughput: one byte per cycle while the result queue has room. The parser
//   classifies each byte in the cycle it is taken; a byte that closes a record
//   and the buffer at once gives two result transactions from one queue entry.
// Path: a result is first written into the queue, then loaded into the output
//   register that presents it.
// Stall: the 4-entry result queue absorbs receiver back-pressure; req_tready
//   drops only while that queue is full.
// Reset: clears parse state, registers (count and values to zero), the queue
//   pointers and the output pending flags. No clearing pass is needed.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dir_record_reserved_fd_filter_top (
   input  logic                                clock,
   input  logic                                reset,
   // input byte stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [drf_pkg::REQ_DATA_W-1:0]      req_tdata,   // [7:0] data_byte
   input  logic                                req_tlast,   // end_of_buffer
   // result stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [15:0] source_offset, [31:16] dest_offset, [48:32] length,
   // [49] malformed, [55:50] zero
   output logic [drf_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic [drf_pkg::KIND_W-1:0]          rsp_tuser,   // [1:0] kind
   output logic                                rsp_tlast,   // last_result
   // register write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [drf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [drf_pkg::FD_W-1:0]            csr_wdata
);

   logic [drf_pkg::COUNT_W-1:0] count_ff, count_in;
   drf_pkg::fd_table_type       fd_ff, fd_in;

   logic               accept;
   logic               push;
   logic               pop;
   logic               q_full;
   logic               q_valid;
   drf_pkg::entry_type push_entry;
   drf_pkg::entry_type head_entry;

   // Registers: take every write, ignore indexes past the table.
   assign csr_ready = 1'b1;

   always_comb begin
      count_in = count_ff;
      fd_in    = fd_ff;
      if (csr_valid) begin
         if (csr_index == drf_pkg::REG_RESERVED_COUNT) begin
            count_in = csr_wdata[drf_pkg::COUNT_W-1:0];
         end
         for (int i = 0; i < drf_pkg::MAX_RESERVED; i++) begin
            if (csr_index == drf_pkg::REG_RESERVED_FD_BASE + drf_pkg::CSR_IDX_W'(i)) begin
               fd_in[i] = csr_wdata;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         fd_ff    <= '0;
      end else begin
         count_ff <= count_in;
         fd_ff    <= fd_in;
      end
   end

   // Hold off input only while the result queue has no room.
   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   drf_parse u_parse (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .data_byte      (req_tdata[7:0]),
      .end_of_buffer  (req_tlast),
      .reserved_count (count_ff),
      .reserved_fd    (fd_ff),
      .push           (push),
      .entry          (push_entry)
   );

   drf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .not_empty  (q_valid),
      .full       (q_full)
   );

   drf_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .head_entry (head_entry),
      .head_valid (q_valid),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire
